### rtl/core/sacl_pkg.sv
// Shared types, constants and register codes of the set-associative LRU cache model.
package sacl_pkg;

	// Geometry defaults
	localparam int SETS_DEF = 256;
	localparam int WAYS_DEF = 4;

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 30;
	localparam int STAMP_W = 32;
	localparam int COST_W  = 18;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Block size limits (log2 of bytes)
	localparam logic [3:0] OFF_MIN = 4'd2;
	localparam logic [3:0] OFF_MAX = 4'd12;

	// Cycle charges
	localparam logic [COST_W-1:0] HIT_COST    = COST_W'(1);
	localparam logic [COST_W-1:0] MEM_COST    = COST_W'(100);
	localparam logic [COST_W-1:0] WT_HIT_COST = COST_W'(101);

	// Register reset values
	localparam logic       RST_WRITE_ALLOCATE = 1'b1;
	localparam logic       RST_WRITE_THROUGH  = 1'b0;
	localparam logic [3:0] RST_BLOCK_OFFSET   = 4'd4;
	localparam logic [3:0] RST_INDEX_BITS     = 4'd8;
	localparam logic [2:0] RST_WAYS_IN_USE    = 3'd4;

	// Register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_WRITE_ALLOCATE = 3'd0,
		REG_WRITE_THROUGH  = 3'd1,
		REG_BLOCK_OFFSET   = 3'd2,
		REG_INDEX_BITS     = 3'd3,
		REG_WAYS_IN_USE    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic       write_allocate;
		logic       write_through;
		logic [3:0] block_offset_bits;
		logic [3:0] index_bits;
		logic [2:0] ways_in_use;
	} cfg_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              wrote_back;
		logic [COST_W-1:0] cycle_cost;
	} rsp_t;

	// One way of a set row in the memory
	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} way_t;

endpackage

### rtl/core/sacl_cfg.sv
// APB-style configuration registers of the cache model.
module sacl_cfg
	import sacl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_allocate    <= RST_WRITE_ALLOCATE;
			cfg_q.write_through     <= RST_WRITE_THROUGH;
			cfg_q.block_offset_bits <= RST_BLOCK_OFFSET;
			cfg_q.index_bits        <= RST_INDEX_BITS;
			cfg_q.ways_in_use       <= RST_WAYS_IN_USE;
		end else if (wr_en) begin
			unique case (idx)
				REG_WRITE_ALLOCATE: cfg_q.write_allocate    <= pwdata[0];
				REG_WRITE_THROUGH:  cfg_q.write_through     <= pwdata[0];
				REG_BLOCK_OFFSET:   cfg_q.block_offset_bits <= pwdata[3:0];
				REG_INDEX_BITS:     cfg_q.index_bits        <= pwdata[3:0];
				REG_WAYS_IN_USE:    cfg_q.ways_in_use       <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_WRITE_ALLOCATE: prdata[0]   = cfg_q.write_allocate;
			REG_WRITE_THROUGH:  prdata[0]   = cfg_q.write_through;
			REG_BLOCK_OFFSET:   prdata[3:0] = cfg_q.block_offset_bits;
			REG_INDEX_BITS:     prdata[3:0] = cfg_q.index_bits;
			REG_WAYS_IN_USE:    prdata[2:0] = cfg_q.ways_in_use;
			default:            prdata      = '0;
		endcase
	end

endmodule

### rtl/core/sacl_set_ram.sv
// Set row memory: one write port, one registered read port.
module sacl_set_ram
	import sacl_pkg::*;
#(
	parameter int DEPTH  = SETS_DEF,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write a row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read a row; hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/sacl_update.sv
// Set row update: tag match, fill or LRU victim choice, cost and new row.
module sacl_update
	import sacl_pkg::*;
#(
	parameter int WAYS = WAYS_DEF
) (
	input  way_t [WAYS-1:0]    row,
	input  cfg_t               cfg,
	input  logic               mode,
	input  logic [TAG_W-1:0]   tag,
	input  logic [3:0]         off,
	input  logic [STAMP_W-1:0] stamp,
	output way_t [WAYS-1:0]    new_row,
	output rsp_t               result
);

	localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W  = ($clog2(WAYS + 1) > 3) ? $clog2(WAYS + 1) : 3;
	localparam int WAYS2  = 1 << $clog2(WAYS);

	logic [CNT_W-1:0]   ways_eff;
	logic [WAYS-1:0]    in_use;
	logic [WAYS-1:0]    match;
	logic [WAYS-1:0]    empty;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   empty_idx;
	logic [IDX_W-1:0]   victim;
	logic               hit;
	logic               any_empty;
	logic               wb;
	logic [COST_W-1:0]  mem_cost;
	logic               node_ok    [1:2*WAYS2-1];
	logic [STAMP_W-1:0] node_stamp [1:2*WAYS2-1];
	logic [IDX_W-1:0]   node_idx   [1:2*WAYS2-1];

	// Clamp the way count to one..WAYS
	always_comb begin
		if (cfg.ways_in_use == 3'd0) begin
			ways_eff = CNT_W'(1);
		end else if (CNT_W'(cfg.ways_in_use) > CNT_W'(WAYS)) begin
			ways_eff = CNT_W'(WAYS);
		end else begin
			ways_eff = CNT_W'(cfg.ways_in_use);
		end
	end

	// Match and find the first hit and first empty way
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			in_use[w] = (CNT_W'(w) < ways_eff);
			match[w]  = in_use[w] & row[w].valid & (row[w].tag == tag);
			empty[w]  = in_use[w] & ~row[w].valid;
			if (match[w]) begin
				hit_idx = IDX_W'(w);
			end
			if (empty[w]) begin
				empty_idx = IDX_W'(w);
			end
		end
		hit       = |match;
		any_empty = |empty;
	end

	// Oldest stamp over the ways in use; ties go to the lower way
	always_comb begin
		for (int i = 0; i < WAYS2; i++) begin
			if (i < WAYS) begin
				node_ok[WAYS2+i]    = in_use[i];
				node_stamp[WAYS2+i] = row[i].stamp;
			end else begin
				node_ok[WAYS2+i]    = 1'b0;
				node_stamp[WAYS2+i] = '0;
			end
			node_idx[WAYS2+i] = IDX_W'(i);
		end
		for (int n = WAYS2 - 1; n >= 1; n--) begin
			if (!node_ok[2*n] ||
			    (node_ok[2*n+1] && (node_stamp[2*n+1] < node_stamp[2*n]))) begin
				node_ok[n]    = node_ok[2*n+1];
				node_stamp[n] = node_stamp[2*n+1];
				node_idx[n]   = node_idx[2*n+1];
			end else begin
				node_ok[n]    = node_ok[2*n];
				node_stamp[n] = node_stamp[2*n];
				node_idx[n]   = node_idx[2*n];
			end
		end
	end

	assign victim   = any_empty ? empty_idx : node_idx[1];
	assign wb       = ~any_empty & row[victim].dirty;
	assign mem_cost = MEM_COST << (off - OFF_MIN);

	// Charge the access and build the row to write back
	always_comb begin
		new_row           = row;
		result.hit        = hit;
		result.wrote_back = 1'b0;
		result.cycle_cost = '0;
		priority if (hit) begin
			new_row[hit_idx].stamp = stamp;
			priority if (!mode) begin
				result.cycle_cost = HIT_COST;
			end else if (cfg.write_through) begin
				result.cycle_cost = WT_HIT_COST;
			end else begin
				new_row[hit_idx].dirty = 1'b1;
				result.cycle_cost = cfg.write_allocate ? HIT_COST : MEM_COST;
			end
		end else if (mode && !cfg.write_allocate) begin
			result.cycle_cost = MEM_COST;
		end else begin
			result.wrote_back     = wb;
			result.cycle_cost     = mem_cost
				+ ((mode && cfg.write_through) ? MEM_COST : '0)
				+ (wb ? mem_cost : '0);
			new_row[victim].valid = 1'b1;
			new_row[victim].dirty = mode & ~cfg.write_through;
			new_row[victim].tag   = tag;
			new_row[victim].stamp = stamp;
		end
	end

endmodule

### rtl/core/set_assoc_cache_lru_model_core.sv
// Top level of the set-associative LRU cache model: sequencer, address split, memory.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  req_t  (mode, address)
//   rsp      out        rsp_valid / rsp_stall  rsp_t  (hit, wrote_back, cycle_cost)
//   cfg      in         APB write/read         five registers at 4*i
//
// Each access: the accepting edge reads the set row from the memory into its read register,
// and the lookup state compares, picks the victim and writes the row back.
// A new word is taken only once the lookup is done and the sequencer is back in idle.
// After reset a clearing pass over all SETS rows zeroes valid and dirty, one row a cycle;
// no word is taken during it, configuration writes are.
// A stalled result holds in the output register; the next word is still taken,
// and its write-back waits until the result register is free.
module set_assoc_cache_lru_model_core
	import sacl_pkg::*;
#(
	parameter int SETS = SETS_DEF,
	parameter int WAYS = WAYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int IDX_MAX = $clog2(SETS + 1) - 1;
	localparam int ROW_W   = WAYS * $bits(way_t);

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	state_t             state_q;
	logic [SET_W-1:0]   clr_q;
	logic [STAMP_W-1:0] access_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               mode_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [SET_W-1:0]   set_s1;
	logic [3:0]         off_s1;

	cfg_t               cfg;
	logic [3:0]         off_eff;
	logic [3:0]         ib_eff;
	logic [ADDR_W-1:0]  shifted;
	logic [ADDR_W-1:0]  set_full;
	logic [ADDR_W-1:0]  tag_full;
	logic               accept;
	logic               done;
	logic               rd_en;
	logic               wr_en;
	logic [SET_W-1:0]   wr_addr;
	logic [ROW_W-1:0]   wr_data;
	way_t [WAYS-1:0]    row;
	way_t [WAYS-1:0]    new_row;
	logic [STAMP_W-1:0] stamp_new;
	rsp_t               result;

	sacl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the geometry and split the address
	always_comb begin
		if (cfg.block_offset_bits < OFF_MIN) begin
			off_eff = OFF_MIN;
		end else if (cfg.block_offset_bits > OFF_MAX) begin
			off_eff = OFF_MAX;
		end else begin
			off_eff = cfg.block_offset_bits;
		end
		if (cfg.index_bits > 4'(IDX_MAX)) begin
			ib_eff = 4'(IDX_MAX);
		end else begin
			ib_eff = cfg.index_bits;
		end
		shifted  = req.address >> off_eff;
		set_full = shifted & ((ADDR_W'(1) << ib_eff) - ADDR_W'(1));
		tag_full = shifted >> ib_eff;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid & ~req_stall;
	assign done      = (state_q == ST_LOOKUP) & (~rsp_valid_q | ~rsp_stall);
	assign rd_en     = accept;
	assign stamp_new = access_q + STAMP_W'(1);

	// Clear rows after reset, else write back the updated row
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = done;
			wr_addr = set_s1;
			wr_data = new_row;
		end
	end

	sacl_set_ram #(
		.DEPTH  (SETS),
		.ADDR_W (SET_W),
		.DATA_W (ROW_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (set_full[SET_W-1:0]),
		.rd_data (row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	sacl_update #(
		.WAYS (WAYS)
	) u_update (
		.row     (row),
		.cfg     (cfg),
		.mode    (mode_s1),
		.tag     (tag_s1),
		.off     (off_s1),
		.stamp   (stamp_new),
		.new_row (new_row),
		.result  (result)
	);

	// Sequence clear, accept and lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			access_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (done) begin
						access_q <= stamp_new;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Hold the accepted word's fields for the lookup cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			tag_s1  <= tag_full[TAG_W-1:0];
			set_s1  <= set_full[SET_W-1:0];
			off_s1  <= off_eff;
		end
	end

	// Load the result register; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### verif/set_assoc_cache_lru_model_core_tb.sv
`timescale 1ns / 100ps
// Testbench of the set-associative LRU cache core: directed table, random phases, scoreboard.
module set_assoc_cache_lru_model_core_tb;
	import sacl_pkg::*;

	localparam int ENTRIES  = SETS_DEF * WAYS_DEF;
	localparam int MAX_IB   = $clog2(SETS_DEF + 1) - 1;
	localparam int HOLD_LEN = 300;
	localparam int ERR_SHOW = 40;
	localparam int PHASES   = 8;
	localparam int PHASE_N  = 86;
	localparam int FILL_N   = 60;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [31:0] val;
		req_t        word;
		bit          chk;
		rsp_t        want;
	} stim_row_t;

	typedef struct {
		bit   chk;
		rsp_t want;
	} offer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Predicted cache contents and settings
	logic        line_valid [ENTRIES];
	logic        line_dirty [ENTRIES];
	logic [31:0] line_tag   [ENTRIES];
	logic [31:0] line_stamp [ENTRIES];
	logic [31:0] access_cnt;
	cfg_t        cache_cfg;

	stim_row_t dir_q[$];
	offer_t    offered_q[$];
	rsp_t      cache_rsp_q[$];

	int          err_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic        hold_req = 1'b0;
	int          hold_cycles = 0;

	set_assoc_cache_lru_model_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Look up one access, update the predicted state, return the expected response
	function automatic rsp_t cache_access(req_t word);
		int unsigned off, ib, ways, victim, w, e, base;
		logic [31:0] mem, cost, set_i, tag;
		int found;
		rsp_t res;
		off = 32'(cache_cfg.block_offset_bits);
		if (off < OFF_MIN) off = 32'(OFF_MIN);
		if (off > OFF_MAX) off = 32'(OFF_MAX);
		ib = 32'(cache_cfg.index_bits);
		if (ib > MAX_IB) ib = MAX_IB;
		ways = 32'(cache_cfg.ways_in_use);
		if (ways < 1) ways = 1;
		if (ways > WAYS_DEF) ways = WAYS_DEF;
		mem   = 32'(MEM_COST) << (off - 2);
		set_i = (word.address >> off) & ((32'd1 << ib) - 1);
		tag   = (word.address >> off) >> ib;
		base  = set_i * WAYS_DEF;
		access_cnt = access_cnt + 1;
		found = -1;
		res.hit = 1'b0;
		res.wrote_back = 1'b0;
		cost = '0;
		// compare valid in-use ways, first match wins
		for (w = 0; w < ways; w++)
			if (found < 0 && line_valid[base + w] && line_tag[base + w] == tag)
				found = w;
		if (found >= 0) begin
			e = base + found;
			res.hit = 1'b1;
			line_stamp[e] = access_cnt;
			if (word.mode == MODE_LOAD) begin
				cost = 32'(HIT_COST);
			end else if (cache_cfg.write_through) begin
				cost = 32'(WT_HIT_COST);
			end else begin
				line_dirty[e] = 1'b1;
				cost = cache_cfg.write_allocate ? 32'(HIT_COST) : 32'(MEM_COST);
			end
		end else if (word.mode == MODE_STORE && !cache_cfg.write_allocate) begin
			// store goes around the cache
			cost = 32'(MEM_COST);
		end else begin
			cost = mem;
			if (word.mode == MODE_STORE && cache_cfg.write_through)
				cost = cost + 32'(MEM_COST);
			// lowest invalid way, else smallest stamp with lowest way on a tie
			victim = ways;
			for (w = 0; w < ways; w++)
				if (victim == ways && !line_valid[base + w])
					victim = w;
			if (victim == ways) begin
				victim = 0;
				for (w = 1; w < ways; w++)
					if (line_stamp[base + w] < line_stamp[base + victim])
						victim = w;
				if (line_dirty[base + victim]) begin
					res.wrote_back = 1'b1;
					cost = cost + mem;
				end
			end
			e = base + victim;
			line_tag[e]   = tag;
			line_stamp[e] = access_cnt;
			line_valid[e] = 1'b1;
			line_dirty[e] = (word.mode == MODE_STORE) && !cache_cfg.write_through;
		end
		res.cycle_cost = cost[COST_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (err_cnt < ERR_SHOW)
			$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic add_access(logic mode, logic [31:0] addr, bit chk,
			logic hit, logic wb, int unsigned cost);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.idx = REG_WRITE_ALLOCATE;
		row.val = '0;
		row.word.mode = mode;
		row.word.address = addr;
		row.chk = chk;
		row.want.hit = hit;
		row.want.wrote_back = wb;
		row.want.cycle_cost = COST_W'(cost);
		dir_q.push_back(row);
	endtask

	task automatic add_cfg(reg_idx_t idx, logic [31:0] val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		row.word = '0;
		row.chk = 1'b0;
		row.want = '0;
		dir_q.push_back(row);
	endtask

	// Offer one word after a random gap, return at the accepting edge
	task automatic send_word(req_t word, bit chk, rsp_t want);
		offer_t o;
		o.chk = chk;
		o.want = want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		offered_q.push_back(o);
		req_valid <= 1'b1;
		req <= word;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
	endtask

	// Drop valid, wait for every response, then let the pipeline drain
	task automatic quiesce(int trail);
		req_valid <= 1'b0;
		@(posedge clk);
		while (offered_q.size() != 0 || cache_rsp_q.size() != 0)
			@(posedge clk);
		repeat (trail) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Track register writes into the predicted settings
	always @(posedge clk) begin
		if (arst_n && psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[PADDR_W-1:2]))
				REG_WRITE_ALLOCATE: cache_cfg.write_allocate = pwdata[0];
				REG_WRITE_THROUGH:  cache_cfg.write_through = pwdata[0];
				REG_BLOCK_OFFSET:   cache_cfg.block_offset_bits = pwdata[3:0];
				REG_INDEX_BITS:     cache_cfg.index_bits = pwdata[3:0];
				REG_WAYS_IN_USE:    cache_cfg.ways_in_use = pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Predict each accepted word; typed table values take precedence
	always @(posedge clk) begin : accept_mon
		offer_t o;
		rsp_t p;
		if (arst_n && req_valid && !req_stall) begin
			o = offered_q.pop_front();
			p = cache_access(req);
			cache_rsp_q.push_back(o.chk ? o.want : p);
		end
	end

	// Compare each accepted response with the oldest expectation
	always @(posedge clk) begin : rsp_mon
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cache_rsp_q.size() == 0) begin
				report_mismatch("response with none pending", 32'(rsp.cycle_cost), 0);
			end else begin
				e = cache_rsp_q.pop_front();
				if (rsp.hit !== e.hit)
					report_mismatch("hit", 32'(rsp.hit), 32'(e.hit));
				if (rsp.wrote_back !== e.wrote_back)
					report_mismatch("wrote_back", 32'(rsp.wrote_back), 32'(e.wrote_back));
				if (rsp.cycle_cost !== e.cycle_cost)
					report_mismatch("cycle_cost", 32'(rsp.cycle_cost), 32'(e.cycle_cost));
			end
		end
	end

	// Stall the response side at random; hold off once for a long stretch
	always @(posedge clk) begin
		if (hold_req && hold_cycles < HOLD_LEN) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		stim_row_t row;
		req_t word;
		logic [31:0] tag_pool [6];
		logic [7:0] set_pool [3];
		int unsigned eoff, eib;

		// Start from the power-up state
		for (int i = 0; i < ENTRIES; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_tag[i]   = '0;
			line_stamp[i] = '0;
		end
		access_cnt = '0;
		cache_cfg = '{RST_WRITE_ALLOCATE, RST_WRITE_THROUGH, RST_BLOCK_OFFSET,
			RST_INDEX_BITS, RST_WAYS_IN_USE};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Power-up geometry: 16-byte blocks, 256 sets, 4 ways, memory charge 400
		add_access(MODE_LOAD,  32'h0000_0000, 1, 0, 0, 400);
		add_access(MODE_LOAD,  32'h0000_0000, 1, 1, 0, 1);
		add_access(MODE_STORE, 32'h0000_0004, 1, 1, 0, 1);
		add_access(MODE_LOAD,  32'hFFFF_FFFF, 1, 0, 0, 400);
		add_access(MODE_STORE, 32'hFFFF_FFF0, 1, 1, 0, 1);
		add_access(MODE_STORE, 32'h1234_5678, 1, 0, 0, 400);
		add_access(MODE_LOAD,  32'h0000_1000, 1, 0, 0, 400);
		add_access(MODE_LOAD,  32'h0000_2000, 1, 0, 0, 400);
		add_access(MODE_LOAD,  32'h0000_3000, 1, 0, 0, 400);
		// set 0 full: evict the dirty LRU way, then a clean one
		add_access(MODE_LOAD,  32'h0000_4000, 1, 0, 1, 800);
		add_access(MODE_LOAD,  32'h0000_0000, 1, 0, 0, 400);
		// write-through hit and allocating miss
		add_cfg(REG_WRITE_THROUGH, 1);
		add_access(MODE_STORE, 32'h0000_0008, 1, 1, 0, 101);
		add_access(MODE_STORE, 32'h0000_5000, 1, 0, 0, 500);
		// no allocate: misses go to memory
		add_cfg(REG_WRITE_ALLOCATE, 0);
		add_access(MODE_STORE, 32'h0000_7000, 1, 0, 0, 100);
		// write-back without allocate
		add_cfg(REG_WRITE_THROUGH, 0);
		add_access(MODE_STORE, 32'h0000_5004, 1, 1, 0, 100);
		add_access(MODE_STORE, 32'h0000_9000, 1, 0, 0, 100);
		// largest block
		add_cfg(REG_WRITE_ALLOCATE, 1);
		add_cfg(REG_BLOCK_OFFSET, 12);
		add_access(MODE_LOAD,  32'hFFFF_F000, 1, 0, 0, 102400);
		add_access(MODE_STORE, 32'hFFFF_FABC, 0, 0, 0, 0);
		// out-of-range block size and way count, low side; index bits too high
		add_cfg(REG_BLOCK_OFFSET, 0);
		add_cfg(REG_INDEX_BITS, 15);
		add_cfg(REG_WAYS_IN_USE, 0);
		add_access(MODE_STORE, 32'h0000_0010, 0, 0, 0, 0);
		add_access(MODE_LOAD,  32'h0000_0010, 0, 0, 0, 0);
		add_access(MODE_STORE, 32'h0000_0410, 0, 0, 0, 0);
		// out-of-range block size and way count, high side; no index bits
		add_cfg(REG_BLOCK_OFFSET, 15);
		add_cfg(REG_INDEX_BITS, 0);
		add_cfg(REG_WAYS_IN_USE, 7);
		add_access(MODE_LOAD,  32'h8000_0000, 0, 0, 0, 0);
		add_access(MODE_STORE, 32'h8000_0FFF, 0, 0, 0, 0);
		add_access(MODE_LOAD,  32'h7FFF_F000, 0, 0, 0, 0);

		// Walk the directed table
		foreach (dir_q[i]) begin
			row = dir_q[i];
			if (row.is_cfg) begin
				quiesce(8);
				cfg_write(row.idx, row.val);
			end else begin
				send_word(row.word, row.chk, row.want);
			end
		end

		// Random phases: new settings, then localized traffic with some noise
		for (int p = 0; p < PHASES; p++) begin
			quiesce(8);
			cfg_write(REG_WRITE_ALLOCATE, $urandom_range(1));
			cfg_write(REG_WRITE_THROUGH, $urandom_range(1));
			cfg_write(REG_BLOCK_OFFSET,
				($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(6, 2));
			cfg_write(REG_INDEX_BITS,
				($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8));
			cfg_write(REG_WAYS_IN_USE, $urandom_range(7));
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct <= 0;  end
				1: begin send_idle_pct = 87; stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  stall_pct <= 87; end
				default: begin send_idle_pct = 27; stall_pct <= 27; end
			endcase
			eoff = 32'(cache_cfg.block_offset_bits);
			if (eoff < OFF_MIN) eoff = 32'(OFF_MIN);
			if (eoff > OFF_MAX) eoff = 32'(OFF_MAX);
			eib = 32'(cache_cfg.index_bits);
			if (eib > MAX_IB) eib = MAX_IB;
			foreach (tag_pool[k]) tag_pool[k] = $urandom;
			foreach (set_pool[k]) set_pool[k] = 8'($urandom_range(255));
			for (int i = 0; i < PHASE_N; i++) begin
				word.mode = 1'($urandom_range(1));
				if ($urandom_range(99) < 80)
					word.address = (tag_pool[$urandom_range(5)] << (eoff + eib))
						| ((32'(set_pool[$urandom_range(2)]) & ((32'd1 << eib) - 1)) << eoff)
						| ($urandom & ((32'd1 << eoff) - 1));
				else
					word.address = $urandom;
				send_word(word, 1'b0, '0);
			end
		end

		// Fill the block: long response hold-off while words keep coming
		quiesce(8);
		send_idle_pct = 0;
		stall_pct <= 0;
		hold_req <= 1'b1;
		for (int i = 0; i < FILL_N; i++) begin
			word.mode = 1'($urandom_range(1));
			word.address = {2'($urandom_range(3)), 8'h00, 16'($urandom_range(65535)), 6'h00};
			send_word(word, 1'b0, '0);
		end

		quiesce(20);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
